@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the splitter; the sds_core module uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clock while reset is low.
`define SDS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds.
`define SDS_NEVER(label, cond, msg) \
   `SDS_ASSERT(label, !(cond), msg)

`endif

@@ hw/rtl/sds_pkg.sv @@
// Package with constants, types and helper functions of the delimiter splitter.
package sds_pkg;

   localparam int MAX_DELIM_LEN = 8;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 4;
   localparam int DELIM_W       = 64;
   localparam int COUNT_W       = 16;
   localparam int FILL_W        = $clog2(MAX_DELIM_LEN + 1);
   localparam int CMP_W         = (LEN_W > FILL_W) ? LEN_W : FILL_W;
   localparam int DELIM_BYTES_N = DELIM_W / BYTE_W;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = DELIM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_LEN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_BYTES = CSR_IDX_W'(1);

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam logic OUT_BYTE  = 1'b0;
   localparam logic OUT_END   = 1'b1;

   localparam logic [LEN_W-1:0]   DELIM_LEN_RESET   = LEN_W'(1);
   localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET = DELIM_W'(44);
   localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [FILL_W-1:0]  fill_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic      out_kind;
      byte_type  out_byte;
      logic      final_token;
      count_type token_count;
      logic      last;
   } sds_result_type;

   typedef struct packed {
      logic produce;
      logic retire;
   } sds_step_type;

   function automatic byte_type delim_byte(input logic [DELIM_W-1:0] delim, input int idx);
      byte_type b;
      b = '0;
      if (idx < DELIM_BYTES_N) begin
         b = delim[idx*BYTE_W +: BYTE_W];
      end
      return b;
   endfunction

   function automatic count_type count_inc(input count_type c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

@@ hw/rtl/sds_channels.sv @@
// Valid/ready channel interfaces for the splitter requests and results.
interface sds_req_if import sds_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     kind;
   byte_type data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sds_rsp_if import sds_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      out_kind;
   byte_type  out_byte;
   logic      final_token;
   count_type token_count;
   logic      last;

   modport source (output valid, output out_kind, output out_byte, output final_token,
                   output token_count, output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input final_token,
                 input token_count, input last, output ready);
endinterface

@@ hw/rtl/sds_core.sv @@
// Delimiter window, token state and step logic: one result per enabled cycle.
`include "assert_macros.svh"

module sds_core import sds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [LEN_W-1:0]    delim_len,
   input  logic [DELIM_W-1:0]  delim_bytes,
   input  logic                step_en,
   input  logic                item_kind,
   input  byte_type            item_byte,
   output sds_step_type        step,
   output sds_result_type      result
);

   byte_type  window_ff [MAX_DELIM_LEN];
   byte_type  window_in [MAX_DELIM_LEN];
   byte_type  cand      [MAX_DELIM_LEN];
   fill_type  fill_ff, fill_in;
   logic      has_bytes_ff, has_bytes_in;
   logic      skip_used_ff, skip_used_in;
   count_type tokens_ff, tokens_in;
   fill_type  len_eff;
   logic      pre_pop;
   logic      match;

   always_comb begin
      if (CMP_W'(delim_len) > CMP_W'(MAX_DELIM_LEN)) begin
         len_eff = FILL_W'(MAX_DELIM_LEN);
      end else begin
         len_eff = FILL_W'(delim_len);
      end

      match = 1'b1;
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         cand[i] = (FILL_W'(i) == fill_ff) ? item_byte : window_ff[i];
         if (FILL_W'(i) < len_eff && cand[i] != delim_byte(delim_bytes, i)) begin
            match = 1'b0;
         end
      end

      if (item_kind == KIND_END) begin
         pre_pop = (fill_ff != '0);
      end else begin
         pre_pop = (fill_ff != '0) && (fill_ff >= len_eff);
      end
   end

   always_comb begin
      window_in    = window_ff;
      fill_in      = fill_ff;
      has_bytes_in = has_bytes_ff;
      skip_used_in = skip_used_ff;
      tokens_in    = tokens_ff;
      step         = '0;
      result       = '{out_kind: OUT_BYTE, out_byte: '0, final_token: 1'b0,
                       token_count: tokens_ff, last: 1'b1};

      if (pre_pop) begin
         // The oldest window byte leaves before the request itself is handled.
         for (int i = 0; i < MAX_DELIM_LEN - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         fill_in         = fill_ff - FILL_W'(1);
         has_bytes_in    = 1'b1;
         step.produce    = 1'b1;
         result.out_byte = window_ff[0];
         result.last     = 1'b0;
      end else if (item_kind == KIND_END) begin
         step.produce       = 1'b1;
         step.retire        = 1'b1;
         result.out_kind    = OUT_END;
         result.final_token = 1'b1;
         result.token_count = count_inc(tokens_ff);
         fill_in            = '0;
         has_bytes_in       = 1'b0;
         skip_used_in       = 1'b0;
         tokens_in          = '0;
      end else if (len_eff == '0) begin
         step.produce    = 1'b1;
         step.retire     = 1'b1;
         result.out_byte = item_byte;
         has_bytes_in    = 1'b1;
      end else if ((fill_ff + FILL_W'(1)) == len_eff) begin
         step.retire = 1'b1;
         if (match) begin
            if (!has_bytes_ff && !skip_used_ff) begin
               skip_used_in = 1'b1;
               fill_in      = '0;
            end else begin
               step.produce       = 1'b1;
               result.out_kind    = OUT_END;
               result.token_count = count_inc(tokens_ff);
               tokens_in          = count_inc(tokens_ff);
               has_bytes_in       = 1'b0;
               skip_used_in       = 1'b0;
               fill_in            = '0;
            end
         end else begin
            for (int i = 0; i < MAX_DELIM_LEN - 1; i++) begin
               window_in[i] = cand[i+1];
            end
            step.produce    = 1'b1;
            result.out_byte = cand[0];
            has_bytes_in    = 1'b1;
         end
      end else begin
         step.retire = 1'b1;
         window_in   = cand;
         fill_in     = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         has_bytes_ff <= 1'b0;
         skip_used_ff <= 1'b0;
         tokens_ff    <= '0;
      end else if (step_en) begin
         fill_ff      <= fill_in;
         has_bytes_ff <= has_bytes_in;
         skip_used_ff <= skip_used_in;
         tokens_ff    <= tokens_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         window_ff <= window_in;
      end
   end

   `SDS_NEVER(a_fill_bound, fill_ff > FILL_W'(MAX_DELIM_LEN), "window fill out of range")
   `SDS_ASSERT(a_hold_emits, step_en && !step.retire |-> step.produce && !result.last, "held request step without result")
   `SDS_ASSERT(a_end_clears, step_en && step.retire && item_kind == KIND_END |=> tokens_ff == '0 && fill_ff == '0, "end of string did not clear state")

endmodule

@@ hw/rtl/sds_out_reg.sv @@
// Result register that holds one result until the consumer takes it.
module sds_out_reg import sds_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  sds_result_type  result,
   output logic            slot_free,
   sds_rsp_if.source       rsp_chan
);

   logic           valid_ff, valid_in;
   sds_result_type result_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_kind    = result_ff.out_kind;
   assign rsp_chan.out_byte    = result_ff.out_byte;
   assign rsp_chan.final_token = result_ff.final_token;
   assign rsp_chan.token_count = result_ff.token_count;
   assign rsp_chan.last        = result_ff.last;

endmodule

@@ hw/rtl/string_delimiter_splitter_top.sv @@
// Top level of the multi-byte delimiter string splitter.
// Each request is a string byte or an end-of-string mark; the block returns
// token bytes and token ends, one result per cycle while the consumer is ready.
// A request that yields at most one result retires as it is handled, so a new
// request is taken every cycle while the result register has room. A request
// that first has to push out held window bytes (end of string, or a data byte
// after the delimiter length was lowered) is held while the single result
// register sends them out. The window compare is combinational and parallel.
module string_delimiter_splitter_top import sds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   sds_req_if.sink                req_chan,
   sds_rsp_if.source              rsp_chan
);

   logic [LEN_W-1:0]   delim_len_ff, delim_len_in;
   logic [DELIM_W-1:0] delim_bytes_ff, delim_bytes_in;
   logic               item_valid_ff, item_valid_in;
   logic               item_kind_ff;
   byte_type           item_byte_ff;
   logic               accept;
   logic               slot_free;
   logic               step_en;
   sds_step_type       step;
   sds_result_type     result;

   always_comb begin
      delim_len_in   = delim_len_ff;
      delim_bytes_in = delim_bytes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DELIM_LEN: begin
               delim_len_in = csr_wr_data[LEN_W-1:0];
            end
            CSR_DELIM_BYTES: begin
               delim_bytes_in = csr_wr_data[DELIM_W-1:0];
            end
            default: begin
               delim_len_in = delim_len_ff;
            end
         endcase
      end
   end

   assign step_en        = item_valid_ff && slot_free;
   assign req_chan.ready = !item_valid_ff || (step_en && step.retire);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (step_en && step.retire) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_len_ff   <= DELIM_LEN_RESET;
         delim_bytes_ff <= DELIM_BYTES_RESET;
         item_valid_ff  <= 1'b0;
      end else begin
         delim_len_ff   <= delim_len_in;
         delim_bytes_ff <= delim_bytes_in;
         item_valid_ff  <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_kind_ff <= req_chan.kind;
         item_byte_ff <= req_chan.data_byte;
      end
   end

   sds_core u_core (
      .clock       (clock),
      .reset       (reset),
      .delim_len   (delim_len_ff),
      .delim_bytes (delim_bytes_ff),
      .step_en     (step_en),
      .item_kind   (item_kind_ff),
      .item_byte   (item_byte_ff),
      .step        (step),
      .result      (result)
   );

   sds_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step_en && step.produce),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ tb/string_delimiter_splitter_top_test.sv @@
// Testbench of the delimiter splitter: directed and random strings checked against a predictor.
module string_delimiter_splitter_top_test import sds_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 16;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   sds_req_if req_chan ();
   sds_rsp_if rsp_chan ();

   string_delimiter_splitter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always #5 clock = ~clock;

   // Predictor state and its copy of the delimiter registers.
   logic [LEN_W-1:0]   cur_len = DELIM_LEN_RESET;
   logic [DELIM_W-1:0] cur_delim = DELIM_BYTES_RESET;
   byte_type           win_bytes [MAX_DELIM_LEN];
   int                 win_fill = 0;
   bit                 has_bytes = 1'b0;
   bit                 skip_used = 1'b0;
   count_type          ends_seen = '0;

   sds_result_type token_events [$];
   sds_result_type step_results [$];

   int failures = 0;
   int requests_sent = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_cycles = 0;

   function automatic int active_len();
      return (cur_len > MAX_DELIM_LEN) ? MAX_DELIM_LEN : int'(cur_len);
   endfunction

   function automatic void emit_event(input logic kind, input byte_type value, input logic fin);
      sds_result_type r;
      r.out_kind    = kind;
      r.out_byte    = value;
      r.final_token = fin;
      r.token_count = ends_seen;
      r.last        = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void pop_window();
      byte_type oldest;
      oldest = win_bytes[0];
      for (int i = 1; i < win_fill; i++) begin
         win_bytes[i-1] = win_bytes[i];
      end
      win_fill--;
      has_bytes = 1'b1;
      emit_event(OUT_BYTE, oldest, 1'b0);
   endfunction

   function automatic void close_token(input logic fin);
      if (ends_seen != COUNT_MAX) begin
         ends_seen++;
      end
      emit_event(OUT_END, '0, fin);
      has_bytes = 1'b0;
      skip_used = 1'b0;
      win_fill  = 0;
   endfunction

   function automatic void split_request(input logic kind, input byte_type value);
      int l;
      bit hit;
      l = active_len();
      step_results.delete();
      if (kind == KIND_END) begin
         while (win_fill > 0) pop_window();
         close_token(1'b1);
         ends_seen = '0;
      end else begin
         while (win_fill > 0 && win_fill >= l) pop_window();
         if (l == 0) begin
            has_bytes = 1'b1;
            emit_event(OUT_BYTE, value, 1'b0);
         end else begin
            win_bytes[win_fill] = value;
            win_fill++;
            if (win_fill == l) begin
               hit = 1'b1;
               for (int i = 0; i < l; i++) begin
                  if (win_bytes[i] != cur_delim[i*BYTE_W +: BYTE_W]) hit = 1'b0;
               end
               if (!hit) begin
                  pop_window();
               end else if (!has_bytes && !skip_used) begin
                  skip_used = 1'b1;
                  win_fill  = 0;
               end else begin
                  close_token(1'b0);
               end
            end
         end
      end
      if (step_results.size() > 0) begin
         step_results[step_results.size()-1].last = 1'b1;
      end
      foreach (step_results[i]) token_events.push_back(step_results[i]);
   endfunction

   function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                       input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      sds_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (token_events.size() == 0) begin
            $error("unexpected result: out_kind %0d, out_byte %0h",
                   rsp_chan.out_kind, rsp_chan.out_byte);
            failures++;
         end else begin
            want = token_events.pop_front();
            check_field("out_kind", want.out_kind, rsp_chan.out_kind);
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("final_token", want.final_token, rsp_chan.final_token);
            check_field("token_count", want.token_count, rsp_chan.token_count);
            check_field("last", want.last, rsp_chan.last);
         end
      end
   end

   initial begin : drive_rsp_ready
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_request(input logic kind, input byte_type value);
      @(negedge clock);
      if ($urandom_range(99, 0) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99, 0) < sender_idle_pct);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.data_byte <= value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      split_request(kind, value);
      requests_sent++;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (token_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_delimiter(input logic [LEN_W-1:0] len, input logic [DELIM_W-1:0] pattern);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_DELIM_LEN;
      csr_wr_data <= CSR_DATA_W'(len);
      @(negedge clock);
      csr_index   <= CSR_DELIM_BYTES;
      csr_wr_data <= pattern;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_len   = len;
      cur_delim = pattern;
   endtask

   function automatic byte_type pick_byte();
      int l;
      int idx;
      l = active_len();
      if (l > 0 && $urandom_range(99, 0) < 55) begin
         idx = $urandom_range(l - 1, 0);
         return cur_delim[idx*BYTE_W +: BYTE_W];
      end
      return byte_type'($urandom_range(255, 0));
   endfunction

   task automatic send_delimiter(input int count);
      int i;
      for (i = 0; i < count; i++) send_request(KIND_DATA, cur_delim[i*BYTE_W +: BYTE_W]);
   endtask

   task automatic send_string(input int max_tokens, input bit terminate);
      int l;
      int t;
      int ntok;
      l = active_len();
      ntok = $urandom_range(max_tokens, 1);
      for (t = 0; t < ntok; t++) begin
         repeat ($urandom_range(4, 0)) send_request(KIND_DATA, pick_byte());
         repeat ($urandom_range(3, 0)) send_delimiter(l);
         if ($urandom_range(99, 0) < 20) send_delimiter($urandom_range(l, 0));
         if ($urandom_range(99, 0) < 8) begin
            send_request(KIND_END, byte_type'($urandom_range(255, 0)));
         end
      end
      if (terminate) send_request(KIND_END, byte_type'($urandom_range(255, 0)));
   endtask

   // Reset delimiter: a double comma collapses, a third gives an empty token,
   // a trailing comma gives an empty last token, and an empty string is one token.
   task automatic test_default_comma();
      send_request(KIND_DATA, "a");
      send_request(KIND_DATA, ",");
      send_request(KIND_DATA, ",");
      send_request(KIND_DATA, "b");
      send_request(KIND_DATA, ",");
      send_request(KIND_DATA, ",");
      send_request(KIND_DATA, ",");
      send_request(KIND_END, 8'hFF);
      send_request(KIND_END, 8'h00);
   endtask

   task automatic test_length_extremes();
      settle_block();
      write_delimiter('0, 64'h0000_0000_0000_00FF);
      send_request(KIND_DATA, 8'h00);
      send_request(KIND_DATA, 8'hFF);
      send_request(KIND_END, 8'h5A);
      settle_block();
      write_delimiter('1, 64'hFF00_A55A_0F80_0102);
      send_request(KIND_DATA, "X");
      send_delimiter(MAX_DELIM_LEN);
      send_request(KIND_END, 8'h00);
   endtask

   // Bytes held in the window must leave first once the length is lowered.
   task automatic test_length_lowered();
      send_request(KIND_DATA, 8'h11);
      send_request(KIND_DATA, 8'h22);
      send_request(KIND_DATA, 8'h33);
      settle_block();
      write_delimiter(LEN_W'(1), '0);
      send_request(KIND_DATA, 8'h00);
      send_request(KIND_END, 8'h00);
   endtask

   task automatic test_backpressure();
      int start;
      settle_block();
      write_delimiter(LEN_W'(2), 64'h202C);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles        = 200;
      start = requests_sent;
      while (requests_sent - start < 40) send_string(4, 1'b1);
   endtask

   task automatic test_sender_pause();
      send_string(3, 1'b1);
      settle_block();
      send_string(3, 1'b1);
   endtask

   task automatic test_random_strings();
      int mode;
      int start;
      logic [LEN_W-1:0]   len;
      logic [DELIM_W-1:0] pattern;
      for (mode = 0; mode < 4; mode++) begin
         settle_block();
         case (mode)
            0: begin
               len = LEN_W'($urandom_range(7, 2));
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               len = LEN_W'(MAX_DELIM_LEN);
               sender_idle_pct    = 47;
               receiver_stall_pct = 0;
            end
            2: begin
               len = LEN_W'($urandom_range(15, 0));
               sender_idle_pct    = 0;
               receiver_stall_pct = 47;
            end
            default: begin
               len = LEN_W'($urandom_range(4, 1));
               sender_idle_pct    = 37;
               receiver_stall_pct = 37;
            end
         endcase
         case ($urandom_range(4, 0))
            0, 1: pattern = {$urandom, $urandom};
            2: pattern = {8{byte_type'($urandom_range(255, 0))}};
            3: pattern = '1;
            default: pattern = '0;
         endcase
         write_delimiter(len, pattern);
         start = requests_sent;
         while (requests_sent - start < 35) send_string(4, $urandom_range(99, 0) < 85);
      end
   endtask

   initial begin : run_tests
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_DELIM_LEN;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_DATA;
      req_chan.data_byte = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_comma();
      test_length_extremes();
      test_length_lowered();
      test_backpressure();
      test_sender_pause();
      test_random_strings();

      settle_block();
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
